@@ hdl/clt_pkg.sv @@
package clt_pkg;

  localparam int MAX_ARGS_DEFAULT = 16;
  localparam int KW_COUNT = 18;
  localparam int KW_MAX = 6;
  localparam int KW_LEN_W = 3;
  localparam int TYPE_W = 5;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic [3:0]        idx;
    logic [TYPE_W-1:0] ty;
    status_t           st;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic [TYPE_W-1:0] code;
  } kw_hit_t;

  // Keyword text, first character in the low byte, unused bytes zero.
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    48'h00_4E_49_47_4F_4C,  // LOGIN
    48'h45_54_41_45_52_43,  // CREATE
    48'h00_00_48_53_55_50,  // PUSH
    48'h00_00_00_50_4F_50,  // POP
    48'h00_00_00_50_4F_54,  // TOP
    48'h00_00_00_54_45_53,  // SET
    48'h00_00_00_54_45_47,  // GET
    48'h00_00_00_44_44_41,  // ADD
    48'h00_00_00_42_55_53,  // SUB
    48'h00_00_00_4C_55_4D,  // MUL
    48'h00_00_00_56_49_44,  // DIV
    48'h00_4E_49_47_45_42,  // BEGIN
    48'h54_49_4D_4D_4F_43,  // COMMIT
    48'h00_00_00_45_59_42,  // BYE
    48'h00_00_00_00_4B_4F,  // OK
    48'h44_45_4C_49_41_46,  // FAILED
    48'h00_52_4F_52_52_45,  // ERROR
    48'h00_00_41_54_41_44   // DATA
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd6, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd5, 3'd6, 3'd3, 3'd2, 3'd6, 3'd5, 3'd4
  };

  function automatic kw_hit_t kw_lookup(input logic [8*KW_MAX-1:0] text,
                                        input logic [KW_LEN_W-1:0] len);
    kw_hit_t h;
    h = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (KW_LEN[k] == len && KW_TEXT[k] == text) begin
        h.hit = 1'b1;
        h.code = TYPE_W'(k);
      end
    end
    return h;
  endfunction

endpackage

@@ hdl/command_line_tokenizer_top.sv @@
// A request is registered in the input register, then its results (zero to
// four) enter the result buffer and leave it one per cycle while rsp_stall
// is low. A new request is taken every cycle while each request gives at
// most one result and rsp_stall is low; a request with more results holds
// the input while the result buffer drains. Synchronous active-high reset clears
// all tokenizer state and empties both the input register and the result buffer.
module command_line_tokenizer_top #(
  parameter int MAX_ARGS = clt_pkg::MAX_ARGS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] char_byte,
  input  logic       end_of_message,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] out_kind,
  output logic [7:0] arg_byte,
  output logic [3:0] arg_index,
  output logic [4:0] message_type,
  output logic [1:0] status,
  output logic       last
);

  localparam int CNT_W = $clog2(MAX_ARGS + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ARGS);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_ARGS + 1);
  localparam int KW_MAX = clt_pkg::KW_MAX;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eom;

  // tokenizer state
  logic                             in_token, in_token_next;
  logic                             quoted_mode, quoted_mode_next;
  logic [7:0]                       held_byte, held_byte_next;
  logic                             held_valid, held_valid_next;
  logic                             first_done, first_done_next;
  logic [KW_MAX-1:0][7:0]           kw_buf, kw_buf_next;
  logic [clt_pkg::KW_LEN_W-1:0]     kw_len, kw_len_next;
  logic                             kw_over, kw_over_next;
  logic [clt_pkg::TYPE_W-1:0]       type_code, type_code_next;
  logic [CNT_W-1:0]                 arg_cnt, arg_cnt_next;
  clt_pkg::status_t                 msg_status, msg_status_next;

  // result buffer, entry 0 is presented
  clt_pkg::result_t res_buf [4];
  logic [2:0]       res_cnt;

  // step logic
  logic             ws;
  logic [7:0]       cb [2];
  logic [1:0]       n_cb;
  logic             close_tok;
  clt_pkg::kw_hit_t hit;
  clt_pkg::status_t done_st;
  clt_pkg::result_t res_new [4];
  logic [2:0]       n_res;

  logic rsp_fire;
  logic proc;

  assign rsp_valid = (res_cnt != 3'd0);
  assign rsp_fire  = rsp_valid && !rsp_stall;
  assign proc      = in_valid && (res_cnt == 3'd0 || (res_cnt == 3'd1 && rsp_fire));
  assign req_stall = in_valid && !proc;

  assign out_kind     = res_buf[0].kind;
  assign arg_byte     = res_buf[0].data;
  assign arg_index    = res_buf[0].idx;
  assign message_type = res_buf[0].ty;
  assign status       = res_buf[0].st;
  assign last         = res_buf[0].last;

  always_comb begin
    ws = (in_char == clt_pkg::CHAR_SPACE) ||
         (in_char >= clt_pkg::CHAR_TAB && in_char <= clt_pkg::CHAR_CR);

    in_token_next    = in_token;
    quoted_mode_next = quoted_mode;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    first_done_next  = first_done;
    kw_buf_next      = kw_buf;
    kw_len_next      = kw_len;
    kw_over_next     = kw_over;
    type_code_next   = type_code;
    arg_cnt_next     = arg_cnt;
    msg_status_next  = msg_status;

    cb[0]     = '0;
    cb[1]     = '0;
    n_cb      = 2'd0;
    close_tok = 1'b0;
    hit       = '0;
    done_st   = clt_pkg::ST_OK;
    n_res     = 3'd0;
    for (int i = 0; i < 4; i++) begin
      res_new[i] = '0;
    end

    // classify the character: content bytes first, then a token close
    if (!in_token) begin
      if (!ws) begin
        in_token_next = 1'b1;
        if (quoted_mode) begin
          // next piece of a quoted token: flush held byte, join with a space
          if (held_valid) begin
            cb[0] = held_byte;
            cb[1] = clt_pkg::CHAR_SPACE;
            n_cb  = 2'd2;
          end else begin
            cb[0] = clt_pkg::CHAR_SPACE;
            n_cb  = 2'd1;
          end
          held_byte_next  = in_char;
          held_valid_next = 1'b1;
        end else if (in_char == clt_pkg::CHAR_QUOTE) begin
          quoted_mode_next = 1'b1;
          held_byte_next   = in_char;
          held_valid_next  = 1'b0;
        end else begin
          cb[0] = in_char;
          n_cb  = 2'd1;
        end
      end
    end else if (!ws) begin
      if (quoted_mode) begin
        if (held_valid) begin
          cb[0] = held_byte;
          n_cb  = 2'd1;
        end
        held_byte_next  = in_char;
        held_valid_next = 1'b1;
      end else begin
        cb[0] = in_char;
        n_cb  = 2'd1;
      end
    end else begin
      in_token_next = 1'b0;
      if (quoted_mode) begin
        if (held_byte == clt_pkg::CHAR_QUOTE) begin
          close_tok        = 1'b1;
          quoted_mode_next = 1'b0;
          held_valid_next  = 1'b0;
        end
      end else begin
        close_tok = 1'b1;
      end
    end

    if (in_eom && (quoted_mode_next || in_token_next)) begin
      close_tok = 1'b1;
    end

    for (int i = 0; i < 2; i++) begin
      if (i < int'(n_cb)) begin
        if (!first_done) begin
          if (kw_len_next < clt_pkg::KW_LEN_W'(KW_MAX)) begin
            kw_buf_next[kw_len_next] = cb[i];
            kw_len_next = kw_len_next + 1'b1;
          end else begin
            kw_over_next = 1'b1;
          end
        end else if (msg_status != clt_pkg::ST_UNKNOWN && arg_cnt < CNT_LIMIT) begin
          res_new[n_res[1:0]] = '{kind: clt_pkg::KIND_BYTE, data: cb[i],
                                  idx: 4'(arg_cnt), ty: '0,
                                  st: clt_pkg::ST_OK, last: 1'b0};
          n_res = n_res + 3'd1;
        end
      end
    end

    if (close_tok) begin
      if (!first_done) begin
        first_done_next = 1'b1;
        msg_status_next = clt_pkg::ST_UNKNOWN;
        hit = clt_pkg::kw_lookup(kw_buf_next, kw_len_next);
        if (!kw_over_next && hit.hit) begin
          type_code_next  = hit.code;
          msg_status_next = clt_pkg::ST_OK;
        end
      end else if (msg_status != clt_pkg::ST_UNKNOWN) begin
        if (arg_cnt < CNT_LIMIT) begin
          res_new[n_res[1:0]] = '{kind: clt_pkg::KIND_END, data: '0,
                                  idx: 4'(arg_cnt), ty: '0,
                                  st: clt_pkg::ST_OK, last: 1'b0};
          n_res        = n_res + 3'd1;
          arg_cnt_next = arg_cnt + 1'b1;
        end else begin
          arg_cnt_next    = CNT_SAT;
          msg_status_next = clt_pkg::ST_OVERFLOW;
        end
      end
    end

    if (in_eom) begin
      done_st = first_done_next ? msg_status_next : clt_pkg::ST_EMPTY;
      res_new[n_res[1:0]] = '{kind: clt_pkg::KIND_DONE, data: '0, idx: '0,
                              ty: (done_st == clt_pkg::ST_OK ||
                                   done_st == clt_pkg::ST_OVERFLOW) ?
                                  type_code_next : '0,
                              st: done_st, last: 1'b0};
      n_res = n_res + 3'd1;
      // drop all message state
      in_token_next    = 1'b0;
      quoted_mode_next = 1'b0;
      held_byte_next   = '0;
      held_valid_next  = 1'b0;
      first_done_next  = 1'b0;
      kw_buf_next      = '0;
      kw_len_next      = '0;
      kw_over_next     = 1'b0;
      type_code_next   = '0;
      arg_cnt_next     = '0;
      msg_status_next  = clt_pkg::ST_OK;
    end

    for (int i = 0; i < 4; i++) begin
      res_new[i].last = (3'(i) == n_res - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!req_stall) begin
      in_valid <= req_valid;
    end
    if (!req_stall) begin
      in_char <= char_byte;
      in_eom  <= end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token    <= 1'b0;
      quoted_mode <= 1'b0;
      held_byte   <= '0;
      held_valid  <= 1'b0;
      first_done  <= 1'b0;
      kw_buf      <= '0;
      kw_len      <= '0;
      kw_over     <= 1'b0;
      type_code   <= '0;
      arg_cnt     <= '0;
      msg_status  <= clt_pkg::ST_OK;
    end else if (proc) begin
      in_token    <= in_token_next;
      quoted_mode <= quoted_mode_next;
      held_byte   <= held_byte_next;
      held_valid  <= held_valid_next;
      first_done  <= first_done_next;
      kw_buf      <= kw_buf_next;
      kw_len      <= kw_len_next;
      kw_over     <= kw_over_next;
      type_code   <= type_code_next;
      arg_cnt     <= arg_cnt_next;
      msg_status  <= msg_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 3'd0;
    end else if (proc) begin
      res_cnt <= n_res;
    end else if (rsp_fire) begin
      res_cnt <= res_cnt - 3'd1;
    end
    if (proc) begin
      res_buf <= res_new;
    end else if (rsp_fire) begin
      // advance the buffer by one entry
      for (int i = 0; i < 3; i++) begin
        res_buf[i] <= res_buf[i + 1];
      end
    end
  end

  a_res_cnt_range: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= 3'd4)
    else $error("result buffer count out of range");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_kind == clt_pkg::KIND_DONE |-> last)
    else $error("done result not marked last");

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    proc && in_eom |=> !first_done && arg_cnt == '0 && !in_token && !quoted_mode)
    else $error("message state not cleared after done");

  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    arg_cnt <= CNT_SAT)
    else $error("argument count beyond saturation");

  a_single_res_flow: assert property (@(posedge clk) disable iff (rst)
    proc && n_res == 3'd1 |=> rsp_valid && last)
    else $error("single result not presented as last");

endmodule
